### design/rbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared request codes and front-to-back control types.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // Request type codes as they arrive on req_type_i
  localparam logic [1:0] REQ_INVALIDATE = 2'd0;
  localparam logic [1:0] REQ_KNOW       = 2'd1;
  localparam logic [1:0] REQ_FORWARD    = 2'd2;
  localparam logic [1:0] REQ_BACKWARD   = 2'd3;

  typedef enum logic [1:0] {
    OP_INVALIDATE,
    OP_KNOW,
    OP_FORWARD,
    OP_BACKWARD
  } req_op_e;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic    valid;
    req_op_e op;
  } cmd_ctl_t;

endpackage

### design/region_boundary_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_boundary_cache_unit
// Sorted boundary table with known/unknown bits, revalidation and lookups.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | start / busy         | req_type_i, arg_first_i, arg_second_i,
//            |                      | buffer_end_now_i
//  result    | done_o (1-cycle)     | known_bit_o, change_pos_o, status_o
//
// Flow: an invalidate beat goes from the idle state straight to its result
//   strobe. The other requests are bounded by the single read port of the
//   boundary table: a snapshot pass, up to five binary searches, up to
//   eight move passes over the table (five in revalidation, three in a span
//   mark) and, for lookups, a scan over the entries.
// Reset: after reset the INIT state writes entry zero; requests queue meanwhile.
// A two-entry request queue lets new beats in while the back end works;
// busy rises only when that queue is full. Results cannot be stalled.
// A request that would overflow the table restores the snapshot
// and reports status 1.
module region_boundary_cache_unit #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned POS_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic [POS_BITS-1:0] arg_first_i,
  input  logic [POS_BITS-1:0] arg_second_i,
  input  logic [POS_BITS-1:0] buffer_end_now_i,
  output logic                done_o,
  output logic                known_bit_o,
  output logic [POS_BITS-1:0] change_pos_o,
  output logic                status_o
);

  rbc_pkg::cmd_ctl_t   cmd;
  logic [POS_BITS-1:0] cmd_a, cmd_c, cmd_now;
  logic                cmd_pop;

  // front: decode and queue request beats
  rbc_front #(.POS_BITS(POS_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_type_i,
    .arg_first_i,
    .arg_second_i,
    .buffer_end_now_i,
    .cmd_o (cmd),
    .a_o   (cmd_a),
    .c_o   (cmd_c),
    .now_o (cmd_now),
    .pop_i (cmd_pop)
  );

  // back: table sequencer, one request at a time
  rbc_back #(.TABLE_DEPTH(TABLE_DEPTH), .POS_BITS(POS_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .a_i          (cmd_a),
    .c_i          (cmd_c),
    .now_i        (cmd_now),
    .pop_o        (cmd_pop),
    .done_o,
    .known_bit_o,
    .change_pos_o,
    .status_o
  );

endmodule

### design/rbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_front
// Accepts request beats, decodes the request type and queues them (2 deep).
// ----------------------------------------------------------------------------
module rbc_front #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [POS_BITS-1:0]  arg_first_i,
  input  logic [POS_BITS-1:0]  arg_second_i,
  input  logic [POS_BITS-1:0]  buffer_end_now_i,
  output rbc_pkg::cmd_ctl_t    cmd_o,
  output logic [POS_BITS-1:0]  a_o,
  output logic [POS_BITS-1:0]  c_o,
  output logic [POS_BITS-1:0]  now_o,
  input  logic                 pop_i
);

  rbc_pkg::req_op_e    op_q   [2];
  logic [POS_BITS-1:0] a_q    [2];
  logic [POS_BITS-1:0] c_q    [2];
  logic [POS_BITS-1:0] now_q  [2];
  logic                wptr_q, wptr_d;
  logic                rptr_q, rptr_d;
  logic [1:0]          fill_q, fill_d;
  rbc_pkg::req_op_e    dec_op;
  logic                push;
  logic                pop;

  always_comb begin
    unique case (req_type_i)
      rbc_pkg::REQ_INVALIDATE: dec_op = rbc_pkg::OP_INVALIDATE;
      rbc_pkg::REQ_KNOW:       dec_op = rbc_pkg::OP_KNOW;
      rbc_pkg::REQ_FORWARD:    dec_op = rbc_pkg::OP_FORWARD;
      rbc_pkg::REQ_BACKWARD:   dec_op = rbc_pkg::OP_BACKWARD;
      default:                 dec_op = rbc_pkg::OP_INVALIDATE;
    endcase
  end

  assign busy = (fill_q == 2'd2);
  assign push = start && !busy;
  assign pop  = pop_i && (fill_q != 2'd0);

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wptr_q]  <= dec_op;
      a_q[wptr_q]   <= arg_first_i;
      c_q[wptr_q]   <= arg_second_i;
      now_q[wptr_q] <= buffer_end_now_i;
    end
  end

  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.op    = op_q[rptr_q];
  assign a_o         = a_q[rptr_q];
  assign c_o         = c_q[rptr_q];
  assign now_o       = now_q[rptr_q];

endmodule

### design/rbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_back
// Sequencer that runs revalidation, span updates and lookups on the table.
// ----------------------------------------------------------------------------
module rbc_back #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned POS_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbc_pkg::cmd_ctl_t   cmd_i,
  input  logic [POS_BITS-1:0] a_i,
  input  logic [POS_BITS-1:0] c_i,
  input  logic [POS_BITS-1:0] now_i,
  output logic                pop_o,
  output logic                done_o,
  output logic                known_bit_o,
  output logic [POS_BITS-1:0] change_pos_o,
  output logic                status_o
);

  localparam int unsigned PW = POS_BITS;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EW = PW + 1;
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  localparam logic [5:0] ST_INIT = 6'd0;
  localparam logic [5:0] ST_IDLE = 6'd1;
  localparam logic [5:0] ST_MOVE = 6'd2;
  localparam logic [5:0] ST_RV0  = 6'd3;
  localparam logic [5:0] ST_RV1A = 6'd4;
  localparam logic [5:0] ST_RV1B = 6'd5;
  localparam logic [5:0] ST_RV2A = 6'd6;
  localparam logic [5:0] ST_RV2B = 6'd7;
  localparam logic [5:0] ST_RV2C = 6'd8;
  localparam logic [5:0] ST_RV2D = 6'd9;
  localparam logic [5:0] ST_RV2E = 6'd10;
  localparam logic [5:0] ST_RV2F = 6'd11;
  localparam logic [5:0] ST_RV2G = 6'd12;
  localparam logic [5:0] ST_RVND = 6'd13;
  localparam logic [5:0] ST_KNOW = 6'd14;
  localparam logic [5:0] ST_QRY  = 6'd15;
  localparam logic [5:0] ST_F0   = 6'd16;
  localparam logic [5:0] ST_F1   = 6'd17;
  localparam logic [5:0] ST_F2   = 6'd18;
  localparam logic [5:0] ST_F3   = 6'd19;
  localparam logic [5:0] ST_B0   = 6'd20;
  localparam logic [5:0] ST_B1   = 6'd21;
  localparam logic [5:0] ST_B2   = 6'd22;
  localparam logic [5:0] ST_B3   = 6'd23;
  localparam logic [5:0] ST_OUT  = 6'd24;
  localparam logic [5:0] ST_RB1  = 6'd25;
  localparam logic [5:0] ST_SS0  = 6'd26;
  localparam logic [5:0] ST_SS1  = 6'd27;
  localparam logic [5:0] ST_SS2  = 6'd28;
  localparam logic [5:0] ST_SS3  = 6'd29;
  localparam logic [5:0] ST_SS4  = 6'd30;
  localparam logic [5:0] ST_SS5  = 6'd31;
  localparam logic [5:0] ST_SS6  = 6'd32;
  localparam logic [5:0] ST_SS7  = 6'd33;
  localparam logic [5:0] ST_SS8  = 6'd34;
  localparam logic [5:0] ST_SS9  = 6'd35;
  localparam logic [5:0] ST_SS10 = 6'd36;
  localparam logic [5:0] ST_SS11 = 6'd37;
  localparam logic [5:0] ST_LC1  = 6'd38;
  localparam logic [5:0] ST_LC2  = 6'd39;

  // table RAMs: T is the live table, S the snapshot for rollback
  logic          t_we, s_we;
  logic [IW-1:0] t_wa, t_ra, s_wa, s_ra;
  logic [EW-1:0] t_wd, t_rd, s_wd, s_rd;
  logic [PW-1:0] t_pos;
  logic          t_bit;

  rbc_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_live (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );
  rbc_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_snap (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  assign t_pos = t_rd[EW-1:1];
  assign t_bit = t_rd[0];

  logic [5:0]    state_q, state_d, mv_ret_q, mv_ret_d, loc_ret_q, loc_ret_d;
  logic [5:0]    ss_ret_q, ss_ret_d;
  logic [CW-1:0] cnt_q, cnt_d, scnt_q, scnt_d;
  logic [PW-1:0] kend_q, kend_d, head_q, head_d, tail_q, tail_d;
  logic [PW-1:0] skend_q, skend_d, shead_q, shead_d, stail_q, stail_d;
  rbc_pkg::req_op_e op_q, op_d;
  logic [PW-1:0] a_q, a_d, c_q, c_d, now_q, now_d;
  // move engine
  logic [CW-1:0] mv_rd_q, mv_rd_d, mv_rem_q, mv_rem_d, mv_off_q, mv_off_d;
  logic [CW-1:0] mv_wa_q, mv_wa_d;
  logic          mv_pend_q, mv_pend_d, mv_down_q, mv_down_d;
  logic          mv_srcs_q, mv_srcs_d, mv_dsts_q, mv_dsts_d;
  logic [PW-1:0] mv_add_q, mv_add_d;
  // binary search
  logic [PW-1:0] loc_p_q, loc_p_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  // span update
  logic [PW-1:0] ss_s_q, ss_s_d, ss_e_q, ss_e_d, epos_q, epos_d;
  logic          ss_v_q, ss_v_d, vend_q, vend_d, ebit_q, ebit_d;
  logic [CW-1:0] si_q, si_d, ei_q, ei_d, b_q, b_d, j_q, j_d;
  // lookup and result
  logic          qbit_q, qbit_d;
  logic [PW-1:0] qpos_q, qpos_d;
  logic          res_bit_q, res_bit_d, res_st_q, res_st_d;
  logic [PW-1:0] res_pos_q, res_pos_d;

  // sub-operation launch requests
  logic          go_loc, go_ss, go_del, go_ins, go_shift, go_rb;
  logic [PW-1:0] call_p, call_e;
  logic          call_v;
  logic [CW-1:0] call_lo, call_hi;
  logic [5:0]    call_ret;

  always_comb begin
    logic [EW-1:0] src_w;
    logic [PW-1:0] unch, s_cl, e_cl;
    logic [PW:0]   h1;
    logic [CW:0]   msum;

    state_d = state_q;   mv_ret_d = mv_ret_q; loc_ret_d = loc_ret_q; ss_ret_d = ss_ret_q;
    cnt_d = cnt_q;       scnt_d = scnt_q;     kend_d = kend_q;       head_d = head_q;
    tail_d = tail_q;     skend_d = skend_q;   shead_d = shead_q;     stail_d = stail_q;
    op_d = op_q;         a_d = a_q;           c_d = c_q;             now_d = now_q;
    mv_rd_d = mv_rd_q;   mv_rem_d = mv_rem_q; mv_off_d = mv_off_q;   mv_wa_d = mv_wa_q;
    mv_pend_d = mv_pend_q; mv_down_d = mv_down_q; mv_srcs_d = mv_srcs_q;
    mv_dsts_d = mv_dsts_q; mv_add_d = mv_add_q;
    loc_p_d = loc_p_q;   lo_d = lo_q;         hi_d = hi_q;           mid_d = mid_q;
    ss_s_d = ss_s_q;     ss_e_d = ss_e_q;     epos_d = epos_q;       ss_v_d = ss_v_q;
    vend_d = vend_q;     ebit_d = ebit_q;     si_d = si_q;           ei_d = ei_q;
    b_d = b_q;           j_d = j_q;           qbit_d = qbit_q;       qpos_d = qpos_q;
    res_bit_d = res_bit_q; res_st_d = res_st_q; res_pos_d = res_pos_q;

    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    pop_o = 1'b0;

    go_loc = 1'b0; go_ss = 1'b0; go_del = 1'b0; go_ins = 1'b0; go_shift = 1'b0;
    go_rb = 1'b0;
    call_p = '0; call_e = '0; call_v = 1'b0; call_lo = '0; call_hi = '0;
    call_ret = ST_IDLE;

    src_w = mv_srcs_q ? s_rd : t_rd;
    unch  = kend_q - tail_q;
    h1    = {1'b0, head_q} + 1'b1;
    s_cl  = (ss_s_q == '0) ? PW'(1) : ss_s_q;
    e_cl  = (ss_e_q > kend_q) ? kend_q : ss_e_q;
    msum  = {1'b0, lo_q} + {1'b0, hi_q};

    unique case (state_q)
      ST_INIT: begin
        // entry zero always sits at position one
        t_we    = 1'b1;
        t_wd    = {PW'(1), 1'b0};
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          pop_o     = 1'b1;
          op_d      = cmd_i.op;
          a_d       = a_i;
          c_d       = c_i;
          now_d     = now_i;
          res_bit_d = 1'b0;
          res_pos_d = '0;
          res_st_d  = 1'b0;
          if (cmd_i.op == rbc_pkg::OP_INVALIDATE) begin
            head_d  = (a_i < head_q) ? a_i : head_q;
            tail_d  = (c_i < tail_q) ? c_i : tail_q;
            state_d = ST_OUT;
          end else begin
            // snapshot for rollback on a full table
            scnt_d    = cnt_q;
            skend_d   = kend_q;
            shead_d   = head_q;
            stail_d   = tail_q;
            mv_rd_d   = '0;
            mv_rem_d  = cnt_q;
            mv_off_d  = '0;
            mv_add_d  = '0;
            mv_down_d = 1'b0;
            mv_srcs_d = 1'b0;
            mv_dsts_d = 1'b1;
            mv_pend_d = 1'b0;
            mv_ret_d  = ST_RV0;
            state_d   = ST_MOVE;
          end
        end
      end
      ST_MOVE: begin
        if (mv_pend_q) begin
          if (mv_dsts_q) begin
            s_we = 1'b1;
            s_wa = mv_wa_q[IW-1:0];
            s_wd = {src_w[EW-1:1] + mv_add_q, src_w[0]};
          end else begin
            t_we = 1'b1;
            t_wa = mv_wa_q[IW-1:0];
            t_wd = {src_w[EW-1:1] + mv_add_q, src_w[0]};
          end
        end
        if (mv_srcs_q) begin
          s_ra = mv_rd_q[IW-1:0];
        end else begin
          t_ra = mv_rd_q[IW-1:0];
        end
        if (mv_rem_q != '0) begin
          mv_rd_d   = mv_down_q ? (mv_rd_q - 1'b1) : (mv_rd_q + 1'b1);
          mv_rem_d  = mv_rem_q - 1'b1;
          mv_wa_d   = mv_rd_q + mv_off_q;
          mv_pend_d = 1'b1;
        end else begin
          mv_pend_d = 1'b0;
          state_d   = mv_ret_q;
        end
      end
      ST_RV0: begin
        if ((tail_q > kend_q) || (head_q >= unch)) begin
          state_d = ST_KNOW;
        end else if (h1 == {1'b0, unch}) begin
          go_loc = 1'b1; call_p = h1[PW-1:0]; call_ret = ST_RV1A;
        end else begin
          go_ss = 1'b1; call_p = h1[PW-1:0]; call_e = unch; call_v = 1'b0;
          call_ret = ST_RV2A;
        end
      end
      ST_RV1A: begin
        go_shift = 1'b1; call_lo = lo_q; call_ret = ST_RV1B;
      end
      ST_RV1B: begin
        if ((tail_q <= now_q) && (head_q != '1)) begin
          go_ss = 1'b1; call_p = h1[PW-1:0]; call_e = now_q - tail_q; call_v = 1'b0;
          call_ret = ST_RVND;
        end else begin
          state_d = ST_RVND;
        end
      end
      ST_RV2A: begin
        go_loc = 1'b1; call_p = h1[PW-1:0]; call_ret = ST_RV2B;
      end
      ST_RV2B: begin
        b_d = lo_q;
        go_shift = 1'b1; call_lo = lo_q; call_ret = ST_RV2C;
      end
      ST_RV2C: begin
        if ((b_q + 1'b1) < cnt_q) begin
          t_ra    = IW'(b_q + 1'b1);
          state_d = ST_RV2D;
        end else begin
          state_d = ST_RVND;
        end
      end
      ST_RV2D: begin
        epos_d  = t_pos;
        ebit_d  = t_bit;
        t_ra    = b_q[IW-1:0];
        state_d = ST_RV2E;
      end
      ST_RV2E: begin
        // two boundaries landed on the same position: merge them
        if (t_pos == epos_q) begin
          if (b_q != '0) begin
            t_ra    = IW'(b_q - 1'b1);
            state_d = ST_RV2F;
          end else begin
            state_d = ST_RV2G;
          end
        end else begin
          state_d = ST_RVND;
        end
      end
      ST_RV2F: begin
        if (t_bit == ebit_q) begin
          go_del = 1'b1; call_lo = b_q; call_hi = b_q + CW'(2); call_ret = ST_RVND;
        end else begin
          state_d = ST_RV2G;
        end
      end
      ST_RV2G: begin
        t_we = 1'b1;
        t_wa = b_q[IW-1:0];
        t_wd = {epos_q, ebit_q};
        go_del = 1'b1; call_lo = b_q + 1'b1; call_hi = b_q + CW'(2); call_ret = ST_RVND;
      end
      ST_RVND: begin
        head_d  = kend_q - 1'b1;
        tail_d  = kend_q - 1'b1;
        state_d = ST_KNOW;
      end
      ST_KNOW: begin
        if (op_q == rbc_pkg::OP_KNOW) begin
          go_ss = 1'b1; call_p = a_q; call_e = c_q; call_v = 1'b1; call_ret = ST_QRY;
        end else begin
          state_d = ST_QRY;
        end
      end
      ST_QRY: begin
        unique case (op_q)
          rbc_pkg::OP_FORWARD: begin
            if (a_q >= now_q) begin
              res_pos_d = now_q;
              state_d   = ST_OUT;
            end else begin
              go_loc = 1'b1; call_p = a_q; call_ret = ST_F0;
            end
          end
          rbc_pkg::OP_BACKWARD: begin
            if (a_q <= PW'(1)) begin
              res_pos_d = PW'(1);
              state_d   = ST_OUT;
            end else begin
              go_loc = 1'b1; call_p = a_q - 1'b1; call_ret = ST_B0;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_F0: begin
        t_ra    = lo_q[IW-1:0];
        j_d     = lo_q + 1'b1;
        state_d = ST_F1;
      end
      ST_F1: begin
        qbit_d  = t_bit;
        state_d = ST_F2;
      end
      ST_F2: begin
        if (j_q < cnt_q) begin
          t_ra    = j_q[IW-1:0];
          state_d = ST_F3;
        end else begin
          res_bit_d = qbit_q;
          res_pos_d = now_q;
          state_d   = ST_OUT;
        end
      end
      ST_F3: begin
        if (t_bit != qbit_q) begin
          res_bit_d = qbit_q;
          res_pos_d = t_pos;
          state_d   = ST_OUT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_F2;
        end
      end
      ST_B0: begin
        t_ra    = lo_q[IW-1:0];
        j_d     = lo_q;
        state_d = ST_B1;
      end
      ST_B1: begin
        qbit_d  = t_bit;
        qpos_d  = t_pos;
        state_d = ST_B2;
      end
      ST_B2: begin
        if (j_q != '0) begin
          t_ra    = IW'(j_q - 1'b1);
          state_d = ST_B3;
        end else begin
          res_bit_d = qbit_q;
          res_pos_d = PW'(1);
          state_d   = ST_OUT;
        end
      end
      ST_B3: begin
        if (t_bit == qbit_q) begin
          j_d     = j_q - 1'b1;
          qpos_d  = t_pos;
          state_d = ST_B2;
        end else begin
          res_bit_d = qbit_q;
          res_pos_d = qpos_q;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      ST_RB1: begin
        res_bit_d = 1'b0;
        res_pos_d = '0;
        res_st_d  = 1'b1;
        state_d   = ST_OUT;
      end
      // ---- span clear / mark ----
      ST_SS0: begin
        ss_s_d = s_cl;
        ss_e_d = e_cl;
        if (s_cl >= e_cl) begin
          state_d = ss_ret_q;
        end else begin
          go_loc = 1'b1; call_p = s_cl; call_ret = ST_SS1;
        end
      end
      ST_SS1: begin
        si_d = lo_q;
        go_loc = 1'b1; call_p = ss_e_q - 1'b1; call_ret = ST_SS2;
      end
      ST_SS2: begin
        ei_d    = lo_q + 1'b1;
        t_ra    = lo_q[IW-1:0];
        state_d = ST_SS3;
      end
      ST_SS3: begin
        vend_d = t_bit;
        if (ei_q > (si_q + 1'b1)) begin
          go_del = 1'b1; call_lo = si_q + 1'b1; call_hi = ei_q; call_ret = ST_SS4;
        end else begin
          state_d = ST_SS4;
        end
      end
      ST_SS4: begin
        t_ra    = si_q[IW-1:0];
        state_d = ST_SS5;
      end
      ST_SS5: begin
        epos_d = t_pos;
        if (t_pos == ss_s_q) begin
          if (si_q != '0) begin
            t_ra    = IW'(si_q - 1'b1);
            state_d = ST_SS6;
          end else begin
            t_we    = 1'b1;
            t_wa    = si_q[IW-1:0];
            t_wd    = {t_pos, ss_v_q};
            state_d = ST_SS8;
          end
        end else if (t_bit != ss_v_q) begin
          if (cnt_q >= FULL) begin
            go_rb = 1'b1;
          end else begin
            go_ins = 1'b1; call_lo = si_q + 1'b1; call_ret = ST_SS7;
          end
        end else begin
          state_d = ST_SS8;
        end
      end
      ST_SS6: begin
        if (t_bit == ss_v_q) begin
          si_d = si_q - 1'b1;
          go_del = 1'b1; call_lo = si_q; call_hi = si_q + 1'b1; call_ret = ST_SS8;
        end else begin
          t_we    = 1'b1;
          t_wa    = si_q[IW-1:0];
          t_wd    = {epos_q, ss_v_q};
          state_d = ST_SS8;
        end
      end
      ST_SS7: begin
        t_we    = 1'b1;
        t_wa    = IW'(si_q + 1'b1);
        t_wd    = {ss_s_q, ss_v_q};
        si_d    = si_q + 1'b1;
        state_d = ST_SS8;
      end
      ST_SS8: begin
        ei_d = si_q + 1'b1;
        if (ss_e_q == kend_q) begin
          state_d = ss_ret_q;
        end else if ((si_q + 1'b1) >= cnt_q) begin
          state_d = ST_SS10;
        end else begin
          t_ra    = IW'(si_q + 1'b1);
          state_d = ST_SS9;
        end
      end
      ST_SS9: begin
        if (ss_e_q < t_pos) begin
          state_d = ST_SS10;
        end else if (t_bit == ss_v_q) begin
          go_del = 1'b1; call_lo = ei_q; call_hi = ei_q + 1'b1; call_ret = ss_ret_q;
        end else begin
          state_d = ss_ret_q;
        end
      end
      ST_SS10: begin
        if (vend_q != ss_v_q) begin
          if (cnt_q >= FULL) begin
            go_rb = 1'b1;
          end else begin
            go_ins = 1'b1; call_lo = ei_q; call_ret = ST_SS11;
          end
        end else begin
          state_d = ss_ret_q;
        end
      end
      ST_SS11: begin
        t_we    = 1'b1;
        t_wa    = ei_q[IW-1:0];
        t_wd    = {ss_e_q, vend_q};
        state_d = ss_ret_q;
      end
      // ---- binary search ----
      ST_LC1: begin
        if (({1'b0, lo_q} + 1'b1) < {1'b0, hi_q}) begin
          mid_d   = msum[CW:1];
          t_ra    = IW'(msum[CW:1]);
          state_d = ST_LC2;
        end else begin
          state_d = loc_ret_q;
        end
      end
      ST_LC2: begin
        if (loc_p_q < t_pos) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q;
        end
        state_d = ST_LC1;
      end
      default: state_d = ST_IDLE;
    endcase

    // launch of sub-operations
    if (go_loc) begin
      loc_p_d   = call_p;
      lo_d      = '0;
      hi_d      = cnt_q;
      loc_ret_d = call_ret;
      state_d   = ST_LC1;
    end
    if (go_ss) begin
      ss_s_d   = call_p;
      ss_e_d   = call_e;
      ss_v_d   = call_v;
      ss_ret_d = call_ret;
      state_d  = ST_SS0;
    end
    if (go_del || go_ins || go_shift || go_rb) begin
      mv_pend_d = 1'b0;
      mv_add_d  = '0;
      mv_srcs_d = 1'b0;
      mv_dsts_d = 1'b0;
      mv_down_d = 1'b0;
      mv_off_d  = '0;
      mv_ret_d  = call_ret;
      state_d   = ST_MOVE;
    end
    if (go_del) begin
      // close up entries [call_lo, call_hi)
      mv_rd_d  = call_hi;
      mv_rem_d = cnt_q - call_hi;
      mv_off_d = call_lo - call_hi;
      cnt_d    = cnt_q - (call_hi - call_lo);
    end
    if (go_ins) begin
      // open a hole at call_lo, moving top down
      mv_rd_d   = cnt_q - 1'b1;
      mv_rem_d  = cnt_q - call_lo;
      mv_off_d  = CW'(1);
      mv_down_d = 1'b1;
      cnt_d     = cnt_q + 1'b1;
    end
    if (go_shift) begin
      mv_rd_d  = call_lo + 1'b1;
      mv_rem_d = cnt_q - call_lo - 1'b1;
      mv_add_d = now_q - kend_q;
      kend_d   = now_q;
    end
    if (go_rb) begin
      cnt_d     = scnt_q;
      kend_d    = skend_q;
      head_d    = shead_q;
      tail_d    = stail_q;
      mv_rd_d   = '0;
      mv_rem_d  = scnt_q;
      mv_srcs_d = 1'b1;
      mv_ret_d  = ST_RB1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= CW'(1);
      kend_q    <= PW'(1);
      head_q    <= '0;
      tail_q    <= '0;
      mv_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      kend_q    <= kend_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      mv_pend_q <= mv_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_ret_q  <= mv_ret_d;  loc_ret_q <= loc_ret_d; ss_ret_q <= ss_ret_d;
    scnt_q    <= scnt_d;    skend_q   <= skend_d;   shead_q  <= shead_d;
    stail_q   <= stail_d;   op_q      <= op_d;      a_q      <= a_d;
    c_q       <= c_d;       now_q     <= now_d;
    mv_rd_q   <= mv_rd_d;   mv_rem_q  <= mv_rem_d;  mv_off_q <= mv_off_d;
    mv_wa_q   <= mv_wa_d;   mv_down_q <= mv_down_d; mv_srcs_q <= mv_srcs_d;
    mv_dsts_q <= mv_dsts_d; mv_add_q  <= mv_add_d;
    loc_p_q   <= loc_p_d;   lo_q      <= lo_d;      hi_q     <= hi_d;
    mid_q     <= mid_d;     ss_s_q    <= ss_s_d;    ss_e_q   <= ss_e_d;
    epos_q    <= epos_d;    ss_v_q    <= ss_v_d;    vend_q   <= vend_d;
    ebit_q    <= ebit_d;    si_q      <= si_d;      ei_q     <= ei_d;
    b_q       <= b_d;       j_q       <= j_d;       qbit_q   <= qbit_d;
    qpos_q    <= qpos_d;    res_bit_q <= res_bit_d; res_st_q <= res_st_d;
    res_pos_q <= res_pos_d;
  end

  assign done_o       = (state_q == ST_OUT);
  assign known_bit_o  = res_bit_q;
  assign change_pos_o = res_pos_q;
  assign status_o     = res_st_q;

endmodule

### tb/tb_region_boundary_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_boundary_cache_unit
// Self-checking bench for the region boundary cache. A behavioral copy of the
// boundary table predicts each result. Directed tests cover the edge cases,
// then random traffic drives invalidate / revalidate sequences and table-fill
// bursts, under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_region_boundary_cache_unit;

  localparam int unsigned DEPTH = 64;
  localparam longint unsigned PMASK = 64'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_WAIT = 1000;  // > one worst-case request

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic [1:0]  req_type_i;
  logic [31:0] arg_first_i, arg_second_i, buffer_end_now_i;
  logic        done_o, known_bit_o, status_o;
  logic [31:0] change_pos_o;

  region_boundary_cache_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .arg_first_i, .arg_second_i,
    .buffer_end_now_i, .done_o, .known_bit_o, .change_pos_o, .status_o
  );

  typedef struct {
    bit        known;
    bit [31:0] change;
    bit        dropped;
  } lookup_answer_t;

  lookup_answer_t pending_answers[$];
  int unsigned    err_count;
  int unsigned    cycle_count;
  int unsigned    idle_pct;
  longint unsigned cur_end;     // buffer end the stimulus is currently using

  // --------------------------------------------------------------------------
  // Shadow boundary table. Positions are kept 64 bits wide so head+1 can
  // reach 2^32 without wrapping, as the block's arithmetic does.
  // --------------------------------------------------------------------------
  longint unsigned shd_pos[DEPTH];
  bit              shd_bit[DEPTH];
  int unsigned     shd_count;
  longint unsigned shd_end, shd_head, shd_tail;
  bit              shd_full;

  function automatic int unsigned find_slot(longint unsigned p);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = shd_count;
    while (lo + 1 < hi) begin
      mid = (lo + hi) >> 1;
      if (p < shd_pos[mid]) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic void open_slot(int unsigned i, longint unsigned p, bit v);
    int unsigned n;
    n = shd_count;
    if (n >= DEPTH) begin
      shd_full = 1'b1;
      return;
    end
    if (i < 1 || i > n) return;
    for (int unsigned k = n; k > i; k--) begin
      shd_pos[k] = shd_pos[k-1];
      shd_bit[k] = shd_bit[k-1];
    end
    shd_pos[i] = p;
    shd_bit[i] = v;
    shd_count  = n + 1;
  endfunction

  function automatic void drop_slots(int unsigned a, int unsigned b);
    int unsigned n;
    n = shd_count;
    if (a < 1 || b > n || a >= b) return;
    for (int unsigned k = a; k + (b - a) < n; k++) begin
      shd_pos[k] = shd_pos[k + (b - a)];
      shd_bit[k] = shd_bit[k + (b - a)];
    end
    shd_count = n - (b - a);
  endfunction

  function automatic void paint_span(longint unsigned s, longint unsigned e, bit v);
    int unsigned si, ei;
    bit vend;
    if (s < 1) s = 1;
    if (e > shd_end) e = shd_end;
    if (s >= e) return;
    si   = find_slot(s);
    ei   = find_slot(e - 1) + 1;
    vend = shd_bit[ei-1];
    if (ei > si + 1) drop_slots(si + 1, ei);
    if (shd_pos[si] == s) begin
      if (si > 0 && shd_bit[si-1] == v) begin
        drop_slots(si, si + 1);
        si--;
      end else begin
        shd_bit[si] = v;
      end
    end else if (shd_bit[si] != v) begin
      open_slot(si + 1, s, v);
      if (shd_full) return;
      si++;
    end
    ei = si + 1;
    // the buffer end itself never carries a boundary
    if (e == shd_end) return;
    if (ei >= shd_count || e < shd_pos[ei]) begin
      if (vend != v) open_slot(ei, e, vend);
    end else if (shd_bit[ei] == v) begin
      drop_slots(ei, ei + 1);
    end
  endfunction

  function automatic void slide_after(int unsigned b, longint unsigned now);
    longint unsigned delta;
    delta = (now - shd_end) & PMASK;
    for (int unsigned i = b + 1; i < shd_count; i++)
      shd_pos[i] = (shd_pos[i] + delta) & PMASK;
    shd_end = now;
  endfunction

  // Clear the edited span, move the tail by the length change, merge.
  function automatic void revalidate_table(longint unsigned now);
    longint unsigned h, t, unch;
    int unsigned b;
    h = shd_head;
    t = shd_tail;
    if (t > shd_end) return;
    unch = shd_end - t;
    if (h >= unch) return;
    if (h + 1 == unch) begin
      b = find_slot(h + 1);
      slide_after(b, now);
      if (t <= now && h < PMASK) paint_span(h + 1, now - t, 1'b0);
    end else begin
      paint_span(h + 1, unch, 1'b0);
      if (shd_full) return;
      b = find_slot(h + 1);
      slide_after(b, now);
      if (b + 1 < shd_count && shd_pos[b] == shd_pos[b+1]) begin
        if (b > 0 && shd_bit[b-1] == shd_bit[b+1]) begin
          drop_slots(b, b + 2);
        end else begin
          shd_bit[b] = shd_bit[b+1];
          drop_slots(b + 1, b + 2);
        end
      end
    end
    shd_head = (shd_end - 1) & PMASK;
    shd_tail = shd_head;
  endfunction

  function automatic void clear_table();
    foreach (shd_pos[i]) begin
      shd_pos[i] = 0;
      shd_bit[i] = 0;
    end
    shd_pos[0] = 1;
    shd_count  = 1;
    shd_end    = 1;
    shd_head   = 0;
    shd_tail   = 0;
    shd_full   = 0;
  endfunction

  function automatic lookup_answer_t predict_boundary_answer(logic [1:0] op,
      longint unsigned a, longint unsigned c, longint unsigned now);
    lookup_answer_t  r;
    longint unsigned sv_pos[DEPTH];
    bit              sv_bit[DEPTH];
    int unsigned     sv_count, i, j;
    longint unsigned sv_end, sv_head, sv_tail;
    r = '{known: 0, change: 0, dropped: 0};
    if (op == rbc_pkg::REQ_INVALIDATE) begin
      if (a < shd_head) shd_head = a;
      if (c < shd_tail) shd_tail = c;
      return r;
    end
    sv_pos = shd_pos;  sv_bit = shd_bit;  sv_count = shd_count;
    sv_end = shd_end;  sv_head = shd_head; sv_tail = shd_tail;
    shd_full = 0;
    revalidate_table(now);
    if (!shd_full && op == rbc_pkg::REQ_KNOW) paint_span(a, c, 1'b1);
    if (shd_full) begin
      // whole request rolls back, revalidation included
      shd_pos = sv_pos;  shd_bit = sv_bit;  shd_count = sv_count;
      shd_end = sv_end;  shd_head = sv_head; shd_tail = sv_tail;
      shd_full  = 0;
      r.dropped = 1;
      return r;
    end
    if (op == rbc_pkg::REQ_FORWARD) begin
      i = find_slot(a);
      r.change = now[31:0];
      if (a < now) begin
        r.known = shd_bit[i];
        for (j = i + 1; j < shd_count; j++)
          if (shd_bit[j] != r.known) begin
            r.change = shd_pos[j][31:0];
            break;
          end
      end
    end else if (op == rbc_pkg::REQ_BACKWARD) begin
      r.change = 1;
      if (a > 1) begin
        i = find_slot(a - 1);
        j = i;
        r.known = shd_bit[i];
        while (j > 0 && shd_bit[j-1] == r.known) j--;
        if (j > 0) r.change = shd_pos[j][31:0];
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    $display("mismatch: %s got %0h want %0h (t=%0t)", what, got, want, $realtime);
    err_count++;
  endtask

  // Result side: done_o is a one-cycle strobe, no back-pressure possible.
  always @(posedge clk_i) begin
    lookup_answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result beat", change_pos_o, 0);
      end else begin
        want = pending_answers.pop_front();
        if (known_bit_o !== want.known)
          report_mismatch("known_bit", known_bit_o, want.known);
        if (change_pos_o !== want.change)
          report_mismatch("change_pos", change_pos_o, want.change);
        if (status_o !== want.dropped)
          report_mismatch("status", status_o, want.dropped);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Hold start until a beat is taken, then maybe go idle for a while. When no
  // gap follows, start stays high so the next call only updates the payload.
  task automatic send_req(logic [1:0] op, logic [31:0] a, logic [31:0] c,
                          logic [31:0] e);
    int unsigned gap;
    start            <= 1'b1;
    req_type_i       <= op;
    arg_first_i      <= a;
    arg_second_i     <= c;
    buffer_end_now_i <= e;
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(predict_boundary_answer(op, a, c, e));
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_pos();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return $urandom;
    if (r < 9) return (r < 7) ? 32'hFFFF_FFFF : 32'd0;
    return $urandom_range(0, int'(cur_end) + 4);
  endfunction

  // Spaced known spans: each adds two boundaries until the table overflows.
  task automatic fill_table();
    int unsigned pitch, k;
    cur_end = $urandom_range(300, 3000);
    pitch   = int'(cur_end) / 45;
    for (k = 0; k < 40; k++)
      send_req(rbc_pkg::REQ_KNOW, k * pitch + $urandom_range(0, 1),
               k * pitch + $urandom_range(2, pitch - 1), cur_end);
    send_req(rbc_pkg::REQ_FORWARD, pick_pos(), 0, cur_end);
    send_req(rbc_pkg::REQ_BACKWARD, pick_pos(), 0, cur_end);
  endtask

  task automatic random_item();
    int unsigned r;
    logic [1:0]  op;
    r  = $urandom_range(99);
    op = (r < 25) ? rbc_pkg::REQ_INVALIDATE : (r < 55) ? rbc_pkg::REQ_KNOW :
         (r < 78) ? rbc_pkg::REQ_FORWARD : rbc_pkg::REQ_BACKWARD;
    // the buffer length sometimes changes, whatever the request type
    r = $urandom_range(99);
    if (r < 4) cur_end = $urandom_range(1, 400);
    else if (r < 7) cur_end = ($urandom == 0) ? 1 : $urandom;
    else if (r < 20) cur_end = (cur_end > 20) ? cur_end + $urandom_range(0, 40) - 20
                                              : cur_end + $urandom_range(0, 20);
    cur_end &= PMASK;
    if (cur_end == 0) cur_end = 1;
    send_req(op, pick_pos(), pick_pos(), cur_end);
  endtask

  task automatic random_phase(int unsigned pct, int unsigned items);
    idle_pct = pct;
    fill_table();
    for (int unsigned n = 0; n < items; n++) random_item();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_lookups_and_spans();
    send_req(rbc_pkg::REQ_BACKWARD, 0, 0, 1);              // backward at buffer start
    send_req(rbc_pkg::REQ_FORWARD, 5, 0, 100);             // first revalidation
    send_req(rbc_pkg::REQ_KNOW, 10, 20, 100);
    send_req(rbc_pkg::REQ_KNOW, 30, 30, 100);              // empty span
    send_req(rbc_pkg::REQ_KNOW, 50, 40, 100);              // reversed span
    send_req(rbc_pkg::REQ_KNOW, 60, 32'hFFFF_FFFF, 100);   // clipped at the end
    send_req(rbc_pkg::REQ_FORWARD, 15, 0, 100);
    send_req(rbc_pkg::REQ_FORWARD, 99, 0, 100);
    send_req(rbc_pkg::REQ_FORWARD, 32'hFFFF_FFFF, 0, 100); // beyond the end
    send_req(rbc_pkg::REQ_BACKWARD, 1, 0, 100);
    send_req(rbc_pkg::REQ_BACKWARD, 15, 0, 100);
    send_req(rbc_pkg::REQ_BACKWARD, 32'hFFFF_FFFF, 0, 100);
    send_req(rbc_pkg::REQ_KNOW, 0, 32'hFFFF_FFFF, 100);    // whole buffer known
  endtask

  task automatic test_invalidate_shift();
    send_req(rbc_pkg::REQ_INVALIDATE, 20, 50, 100);
    send_req(rbc_pkg::REQ_KNOW, 5, 8, 130);                // text grew by 30
    send_req(rbc_pkg::REQ_BACKWARD, 120, 0, 130);
    send_req(rbc_pkg::REQ_INVALIDATE, 0, 0, 130);
    send_req(rbc_pkg::REQ_FORWARD, 3, 0, 1);               // buffer shrunk to nothing
    send_req(rbc_pkg::REQ_INVALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_req(rbc_pkg::REQ_FORWARD, 2, 0, 32'hFFFF_FFFF);   // shift wraps
    send_req(rbc_pkg::REQ_INVALIDATE, 32'hFFFF_FFFE, 0, 32'hFFFF_FFFF);
    send_req(rbc_pkg::REQ_BACKWARD, 32'h8000_0000, 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_table_overflow();
    idle_pct = 0;
    fill_table();                                 // last spans come back dropped
    drain();                                      // sender waits for all results
  endtask

  initial begin
    clear_table();
    err_count        = 0;
    cycle_count      = 0;
    idle_pct         = 0;
    cur_end          = 100;
    rst_ni           = 1'b0;
    start            = 1'b0;
    req_type_i       = rbc_pkg::REQ_INVALIDATE;
    arg_first_i      = '0;
    arg_second_i     = '0;
    buffer_end_now_i = 32'd1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lookups_and_spans();
    test_invalidate_shift();
    test_table_overflow();
    random_phase(0, 60);
    random_phase(88, 60);
    random_phase(20, 60);
    random_phase(0, 40);

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
